// ===== hw/rtl/iut_pkg.sv =====
// Shared types and constants of the interval union table.
package iut_pkg;

    localparam int DEPTH = 64;
    localparam int TB    = 32;
    localparam int IW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    localparam int IN_W  = 72;
    localparam int OUT_W = 80;

    typedef enum logic [1:0] {
        FN_ADD   = 2'd0,
        FN_OVL   = 2'd1,
        FN_POINT = 2'd2,
        FN_READ  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_INV   = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        C_HOLD = 3'd0,
        C_CMP  = 3'd1,
        C_MRG  = 3'd2,
        C_INS  = 3'd3,
        C_DEL  = 3'd4
    } t_cop;

    typedef struct packed {
        logic                 v;
        logic                 d;
        logic                 g;
        logic signed [TB-1:0] lo;
        logic signed [TB-1:0] hi;
    } t_ent;

    typedef struct packed {
        t_cop                 op;
        t_func                func;
        logic signed [TB-1:0] lo;
        logic signed [TB-1:0] hi;
        logic signed [TB-1:0] nlo;
        logic signed [TB-1:0] nhi;
    } t_bcast;

endpackage

// ===== hw/rtl/interval_union_table.sv =====
// Top level of the interval union table: control sequencer over a row of slot cells.
// Keeps up to DEPTH sorted, disjoint half-open intervals in a row of cells. Each beat is
// handled alone: accept, a compare step in which every cell tests the broadcast interval,
// an evaluate step that inserts, merges or answers, and a result step; an add that
// swallows k stored intervals then closes the gap in a delete state, one cell shift per
// cycle for each of the k-1 swallowed neighbors, and leaves it once it sees the run closed.
// The result beat waits on the output while that is stalled, and no new beat is taken
// until it is loaded. The table starts empty after reset; no clearing pass is needed.
module interval_union_table import iut_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  logic [IN_W-1:0]  i_s_axis_tdata,   // func[1:0] lo[33:2] hi[65:34] index[71:66]
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    output logic [OUT_W-1:0] o_m_axis_tdata    // status hit region_index count entry_lo entry_hi
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CMP  = 5'b00010,
        S_EVAL = 5'b00100,
        S_DEL  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state               r_state, n_state;
    t_func                r_func;
    logic signed [TB-1:0] r_lo, r_hi;
    logic [IW-1:0]        r_index;
    logic [CW-1:0]        r_count, n_count;
    t_status              r_status, n_status;
    logic                 r_hit, n_hit;
    logic [IW-1:0]        r_region, n_region;
    logic signed [TB-1:0] r_elo, n_elo, r_ehi, n_ehi;
    logic                 r_ovalid;
    logic [OUT_W-1:0]     r_odata;

    t_bcast               bc;
    t_ent                 ent   [DEPTH];
    t_ent                 lft   [DEPTH];
    t_ent                 rgt   [DEPTH];
    logic [DEPTH-1:0]     dvec;
    logic                 anyd;
    logic signed [TB-1:0] sel_lo, sel_hi;
    logic [IW-1:0]        first_d;
    logic                 out_load;

    localparam t_ent EDGE_L = '{v: 1'b0, d: 1'b0, g: 1'b0, lo: '0, hi: '0};
    localparam t_ent EDGE_R = '{v: 1'b0, d: 1'b0, g: 1'b1, lo: '0, hi: '0};

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            if (gi == 0) begin : g_l0
                assign lft[gi] = EDGE_L;
            end else begin : g_ln
                assign lft[gi] = ent[gi-1];
            end
            if (gi == DEPTH-1) begin : g_r0
                assign rgt[gi] = EDGE_R;
            end else begin : g_rn
                assign rgt[gi] = ent[gi+1];
            end
            assign dvec[gi] = ent[gi].d;
            iut_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_bc    (bc),
                .i_left  (lft[gi]),
                .i_right (rgt[gi]),
                .o_ent   (ent[gi])
            );
        end
    endgenerate

    assign anyd            = |dvec;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign out_load        = (r_state == S_DONE) && (!r_ovalid || i_m_axis_tready);

    // first and last matching cells bound the merge run
    always_comb begin
        sel_lo  = '0;
        sel_hi  = '0;
        first_d = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (dvec[i] && (i == 0 || !dvec[(i == 0) ? 0 : i-1])) begin
                sel_lo = sel_lo | ent[i].lo;
            end
            if (dvec[i] && (i == DEPTH-1 || !dvec[(i == DEPTH-1) ? i : i+1])) begin
                sel_hi = sel_hi | ent[i].hi;
            end
        end
        for (int i = DEPTH-1; i >= 0; i--) begin
            if (dvec[i]) begin
                first_d = IW'(i);
            end
        end
    end

    always_comb begin
        bc.func  = r_func;
        bc.lo    = r_lo;
        bc.hi    = r_hi;
        bc.nlo   = (sel_lo < r_lo) ? sel_lo : r_lo;
        bc.nhi   = (sel_hi > r_hi) ? sel_hi : r_hi;
        bc.op    = C_HOLD;
        n_state  = r_state;
        n_count  = r_count;
        n_status = r_status;
        n_hit    = r_hit;
        n_region = r_region;
        n_elo    = r_elo;
        n_ehi    = r_ehi;
        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                bc.op   = C_CMP;
                n_state = S_EVAL;
            end
            S_EVAL: begin
                n_status = ST_OK;
                n_hit    = 1'b0;
                n_region = '0;
                n_elo    = '0;
                n_ehi    = '0;
                n_state  = S_DONE;
                case (r_func)
                    FN_ADD: begin
                        if (r_lo >= r_hi) begin
                            n_status = ST_INV;
                        end else if (anyd) begin
                            bc.op   = C_MRG;
                            n_state = S_DEL;
                        end else if (r_count >= CW'(DEPTH)) begin
                            n_status = ST_FULL;
                        end else begin
                            bc.op   = C_INS;
                            n_count = r_count + CW'(1);
                        end
                    end
                    FN_OVL, FN_POINT: begin
                        n_hit    = anyd;
                        n_region = first_d;
                    end
                    default: begin
                        if ({1'b0, r_index} < r_count) begin
                            n_elo = ent[r_index].lo;
                            n_ehi = ent[r_index].hi;
                        end else begin
                            n_status = ST_RANGE;
                        end
                    end
                endcase
            end
            S_DEL: begin
                if (anyd) begin
                    bc.op   = C_DEL;
                    n_count = r_count - CW'(1);
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
        if (r_state == S_IDLE && i_s_axis_tvalid) begin
            r_func  <= t_func'(i_s_axis_tdata[1:0]);
            r_lo    <= i_s_axis_tdata[33:2];
            r_hi    <= i_s_axis_tdata[65:34];
            r_index <= i_s_axis_tdata[71:66];
        end
        r_status <= n_status;
        r_hit    <= n_hit;
        r_region <= n_region;
        r_elo    <= n_elo;
        r_ehi    <= n_ehi;
        if (out_load) begin
            r_odata <= {r_ehi, r_elo, r_count, r_region, r_hit, r_status};
        end
    end

endmodule

// ===== hw/rtl/iut_cell.sv =====
// One table slot: holds an interval, compares it to the broadcast, shifts with neighbors.
module iut_cell import iut_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_bcast i_bc,
    input  t_ent   i_left,
    input  t_ent   i_right,
    output t_ent   o_ent
);

    t_ent r_e;
    t_ent n_e;
    logic m_add;
    logic m_ovl;
    logic m_pt;

    assign o_ent = r_e;

    always_comb begin
        m_add = (r_e.lo <= i_bc.hi) && (r_e.hi >= i_bc.lo);
        m_ovl = ((i_bc.lo >= r_e.lo) && (i_bc.lo < r_e.hi)) ||
                ((i_bc.hi > r_e.lo) && (i_bc.hi <= r_e.hi)) ||
                ((r_e.lo >= i_bc.lo) && (r_e.lo < i_bc.hi)) ||
                ((r_e.hi > i_bc.lo) && (r_e.hi <= i_bc.hi));
        m_pt  = (i_bc.lo >= r_e.lo) && (i_bc.lo < r_e.hi);
        n_e   = r_e;
        case (i_bc.op)
            C_CMP: begin
                // g marks slots at or after the insert / merge point
                n_e.g = !r_e.v || m_add || (r_e.lo > i_bc.hi);
                case (i_bc.func)
                    FN_ADD:   n_e.d = r_e.v && m_add;
                    FN_OVL:   n_e.d = r_e.v && m_ovl;
                    FN_POINT: n_e.d = r_e.v && m_pt;
                    default:  n_e.d = 1'b0;
                endcase
            end
            C_MRG: begin
                if (r_e.d && !i_left.d) begin
                    n_e.lo = i_bc.nlo;
                    n_e.hi = i_bc.nhi;
                    n_e.d  = 1'b0;
                    n_e.g  = 1'b0;
                end
            end
            C_INS: begin
                if (r_e.g) begin
                    if (i_left.g) begin
                        n_e.v  = i_left.v;
                        n_e.lo = i_left.lo;
                        n_e.hi = i_left.hi;
                    end else begin
                        n_e.v  = 1'b1;
                        n_e.lo = i_bc.lo;
                        n_e.hi = i_bc.hi;
                    end
                end
            end
            C_DEL: begin
                if (r_e.g) begin
                    n_e = i_right;
                end
            end
            default: n_e = r_e;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e.v <= 1'b0;
            r_e.d <= 1'b0;
            r_e.g <= 1'b0;
        end else begin
            r_e.v <= n_e.v;
            r_e.d <= n_e.d;
            r_e.g <= n_e.g;
        end
        r_e.lo <= n_e.lo;
        r_e.hi <= n_e.hi;
    end

endmodule

// ===== hw/rtl/iut_chk.sv =====
// Port-level checks of the interval union table, bound to the top level.
module iut_chk import iut_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_s_axis_tvalid,
    input logic             o_s_axis_tready,
    input logic [IN_W-1:0]  i_s_axis_tdata,
    input logic             o_m_axis_tvalid,
    input logic             i_m_axis_tready,
    input logic [OUT_W-1:0] o_m_axis_tdata
);

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result beat right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result beat changed");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[15:9] <= CW'(DEPTH))
        else $error("count beyond table depth");

    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[1:0] != ST_OK |->
            !o_m_axis_tdata[2] && o_m_axis_tdata[79:16] == '0)
        else $error("failed beat carries data");

endmodule

bind interval_union_table iut_chk u_iut_chk (.*);
